>>> design/u8s_pkg.sv
// Shared types, constants and the lead-byte decode for the UTF-8 sequence sanitizer.
// Used by u8s_result_queue and utf8_sequence_sanitizer; depends on nothing.
package u8s_pkg;

   localparam int MaxPush        = 4;   // most results one input byte can cause
   localparam int PushCountWidth = 3;   // holds 0 .. MaxPush
   localparam int HeldDepth      = 3;   // lead byte plus up to two continuation bytes

   localparam logic [7:0] AsciiLimit = 8'h80;
   localparam logic [7:0] Lead3Mask  = 8'hE0;
   localparam logic [7:0] Lead2Code  = 8'hC0;
   localparam logic [7:0] Lead4Mask  = 8'hF0;
   localparam logic [7:0] Lead3Code  = 8'hE0;
   localparam logic [7:0] Lead5Mask  = 8'hF8;
   localparam logic [7:0] Lead4Code  = 8'hF0;
   localparam logic [1:0] ContTag    = 2'b10;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       run_last;
      logic       string_end;
   } u8s_result_type;

   typedef struct packed {
      logic [PushCountWidth-1:0]        count;
      u8s_result_type [MaxPush-1:0]     entry;
   } u8s_push_type;

   // Sequence length opened by a byte in lead position; 0 for a byte that cannot lead.
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      begin
         if (b < AsciiLimit) begin
            len = 3'd1;
         end else if ((b & Lead3Mask) == Lead2Code) begin
            len = 3'd2;
         end else if ((b & Lead4Mask) == Lead3Code) begin
            len = 3'd3;
         end else if ((b & Lead5Mask) == Lead4Code) begin
            len = 3'd4;
         end else begin
            len = 3'd0;
         end
         return len;
      end
   endfunction

endpackage

>>> design/u8s_result_queue.sv
// Result queue of the UTF-8 sequence sanitizer: takes up to four results per cycle,
// hands out one per cycle on the stream side while head_ready is high. Depends on u8s_pkg.
module u8s_result_queue #(
   parameter int DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  u8s_pkg::u8s_push_type push,
   output logic                  push_ready,
   output logic                  head_valid,
   input  logic                  head_ready,
   output u8s_pkg::u8s_result_type head
);
   import u8s_pkg::*;

   localparam int PtrWidth   = $clog2(DEPTH);
   localparam int CountWidth = $clog2(DEPTH + 1);

   u8s_result_type              entry_ff [DEPTH];
   logic [PtrWidth-1:0]         wptr_ff, wptr_in;
   logic [PtrWidth-1:0]         rptr_ff, rptr_in;
   logic [CountWidth-1:0]       count_ff, count_in;
   logic                        pop;

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rptr_ff];
   assign pop        = head_valid & head_ready;
   // leave room for a full burst so that readiness never looks at the output side
   assign push_ready = (count_ff <= CountWidth'(DEPTH - MaxPush));

   always_comb begin
      wptr_in  = wptr_ff + PtrWidth'(push.count);
      rptr_in  = rptr_ff + PtrWidth'(pop);
      count_in = count_ff + CountWidth'(push.count) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MaxPush; k++) begin
         if (PushCountWidth'(k) < push.count) begin
            entry_ff[wptr_ff + PtrWidth'(k)] <= push.entry[k];
         end
      end
   end

endmodule

>>> design/utf8_sequence_sanitizer.sv
// Top level of the UTF-8 sequence sanitizer: sequence tracking and result generation.
// Depends on u8s_pkg and u8s_result_queue.
//
// Takes one string byte per cycle while the queue has room and passes on only complete
// sequences with UTF-8 lead and continuation bit patterns. ASCII bytes in lead position
// come out at once; a multi-byte sequence is held until its last byte arrives and then
// comes out as a run of 2 to 4 results, or is dropped whole if any continuation byte is
// not 10xxxxxx or the string ends first. Bytes that cannot lead a sequence are dropped.
// The last input of a string always yields a result with string_end set (an empty
// marker if no byte is kept there). Each input byte is decoded in the cycle it is
// accepted and its results land in the result queue on that edge, so the block takes
// one byte every cycle while the queue has room. Input readiness follows queue space
// only: the queue of QUEUE_DEPTH entries (a power of two, at least 4) accepts while at
// least four entries are free. With 8 or more entries, since no more results leave than
// bytes enter, a consumer that is always ready sees no stall on the input side; with 4
// entries the input takes a new byte only once the queue is empty.
module utf8_sequence_sanitizer #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // string_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_present, [1] string_end
   output logic       rsp_tlast    // run_last
);
   import u8s_pkg::*;

   logic [1:0]     rem_ff, rem_in;
   logic [2:0]     seq_len_ff, seq_len_in;
   logic           seq_ok_ff, seq_ok_in;
   logic [7:0]     held_ff [HeldDepth];
   logic [7:0]     held_in [HeldDepth];

   logic           accept;
   logic [2:0]     lead;
   logic [1:0]     pos;
   logic [1:0]     rem_dec;
   logic           ok_next;
   logic [2:0]     n;
   logic           marker;
   u8s_push_type   push;
   u8s_result_type head;
   logic           push_ready;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = push_ready;

   always_comb begin
      rem_in     = rem_ff;
      seq_len_in = seq_len_ff;
      seq_ok_in  = seq_ok_ff;
      held_in    = held_ff;
      lead       = lead_length(req_tdata);
      pos        = seq_len_ff[1:0] - rem_ff;
      rem_dec    = rem_ff - 2'd1;
      ok_next    = seq_ok_ff & (req_tdata[7:6] == ContTag);
      n          = 3'd0;
      marker     = 1'b0;

      if (rem_ff == 2'd0) begin
         if (lead == 3'd1) begin
            n = 3'd1;
         end else if (lead >= 3'd2) begin
            held_in[0] = req_tdata;
            seq_len_in = lead;
            rem_in     = 2'(lead - 3'd1);
            seq_ok_in  = 1'b1;
         end
      end else if (rem_dec == 2'd0) begin
         if (ok_next) begin
            n = seq_len_ff;
         end
         rem_in     = 2'd0;
         seq_len_in = 3'd0;
         seq_ok_in  = 1'b1;
      end else begin
         rem_in    = rem_dec;
         seq_ok_in = ok_next;
         if (pos < 2'(HeldDepth)) begin
            held_in[pos] = req_tdata;
         end
      end

      // drop a sequence cut off by the end of the string
      if (req_tlast && rem_in != 2'd0) begin
         rem_in     = 2'd0;
         seq_len_in = 3'd0;
         seq_ok_in  = 1'b1;
      end

      if (n == 3'd0 && req_tlast) begin
         marker = 1'b1;
      end

      for (int k = 0; k < MaxPush; k++) begin
         if (marker) begin
            push.entry[k].out_byte     = 8'h00;
            push.entry[k].byte_present = 1'b0;
            push.entry[k].run_last     = 1'b1;
            push.entry[k].string_end   = 1'b1;
         end else begin
            if (PushCountWidth'(k) + 3'd1 < n && k < HeldDepth) begin
               push.entry[k].out_byte = held_ff[k];
            end else begin
               push.entry[k].out_byte = req_tdata;
            end
            push.entry[k].byte_present = 1'b1;
            push.entry[k].run_last     = (PushCountWidth'(k) + 3'd1 == n);
            push.entry[k].string_end   = (PushCountWidth'(k) + 3'd1 == n) & req_tlast;
         end
      end
      push.count = accept ? (marker ? 3'd1 : n) : 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff     <= 2'd0;
         seq_len_ff <= 3'd0;
         seq_ok_ff  <= 1'b1;
      end else if (accept) begin
         rem_ff     <= rem_in;
         seq_len_ff <= seq_len_in;
         seq_ok_ff  <= seq_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   u8s_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = head.out_byte;
   assign rsp_tuser = {head.string_end, head.byte_present};
   assign rsp_tlast = head.run_last;

   // an open sequence always has fewer bytes due than its length
   a_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      rem_ff != 2'd0 |-> seq_len_ff > {1'b0, rem_ff})
      else $error("continuation count exceeds sequence length");

   // the end of a string closes any open sequence
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> rem_ff == 2'd0)
      else $error("sequence left open across string end");

   // the last byte of a string always produces at least one result
   a_last_pushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |-> push.count != 3'd0)
      else $error("string end produced no result");

   // string end only ever marks the final result of a run
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("string_end without run_last");

endmodule
